// File: rtl/core/lru_key_value_cache_macros.svh
// concurrent assertion helpers, clocked on clk and held off during reset
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// same-cycle implication
`define LKV_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LKV_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lkv_pkg.sv
package lkv_pkg;

    localparam int KEY_W = 64;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [VAL_W-1:0] value_t;

    // per-item search context, held steady while the scan runs
    typedef struct packed {
        key_t key;
        logic evict;
    } scan_t;

    // partial result handed from cell to cell
    typedef struct packed {
        logic   hit;
        logic   slot_found;
        value_t value;
    } tok_t;

    // update broadcast to every cell in the apply cycle
    typedef struct packed {
        logic   touch;
        logic   write_value;
        logic   insert;
        value_t value;
    } op_t;

endpackage

// File: rtl/core/lkv_if.sv
interface lkv_req_if;
    logic         valid;
    logic         ready;
    logic         command;
    lkv_pkg::key_t   key;
    lkv_pkg::value_t value;

    modport source (output valid, output command, output key, output value, input ready);
    modport sink   (input valid, input command, input key, input value, output ready);
endinterface

interface lkv_rsp_if;
    logic            valid;
    logic            ready;
    logic            hit;
    lkv_pkg::value_t found_value;

    modport source (output valid, output hit, output found_value, input ready);
    modport sink   (input valid, input hit, input found_value, output ready);
endinterface

// File: rtl/core/lkv_cell.sv
module lkv_cell #(
    parameter int ENTRIES = 16,
    parameter int IDX     = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  lkv_pkg::scan_t                scan,
    input  logic [$clog2(ENTRIES)-1:0]    victim_rank,
    input  lkv_pkg::tok_t                 tok_in,
    input  logic [$clog2(ENTRIES)-1:0]    tok_rank_in,
    input  logic [$clog2(ENTRIES)-1:0]    tok_slot_in,
    output lkv_pkg::tok_t                 tok_out,
    output logic [$clog2(ENTRIES)-1:0]    tok_rank_out,
    output logic [$clog2(ENTRIES)-1:0]    tok_slot_out,
    input  lkv_pkg::op_t                  op,
    input  logic [$clog2(ENTRIES)-1:0]    op_rank,
    input  logic [$clog2(ENTRIES)-1:0]    op_slot,
    output logic                          entry_valid,
    output logic                          entry_match
);
    import lkv_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    logic          valid_reg, valid_next;
    logic [IW-1:0] rank_reg, rank_next;
    key_t          key_reg, key_next;
    value_t        value_reg, value_next;

    tok_t          tok_reg, tok_next;
    logic [IW-1:0] tok_rank_reg, tok_rank_next;
    logic [IW-1:0] tok_slot_reg, tok_slot_next;

    logic match;
    logic is_victim;
    logic is_free;
    logic is_slot;

    assign match     = valid_reg && (key_reg == scan.key);
    assign is_victim = scan.evict && valid_reg && (rank_reg == victim_rank);
    // free once the victim is gone
    assign is_free   = !valid_reg || is_victim;
    assign is_slot   = (op_slot == IW'(IDX));

    // fold this entry into the running search result
    always_comb
    begin
        tok_next.hit        = tok_in.hit || match;
        tok_next.value      = match ? value_reg : tok_in.value;
        tok_rank_next       = match ? rank_reg : tok_rank_in;
        tok_next.slot_found = tok_in.slot_found || is_free;
        tok_slot_next       = tok_in.slot_found ? tok_slot_in : IW'(IDX);
    end

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        key_next   = key_reg;
        value_next = value_reg;
        priority if (clear)
        begin
            valid_next = 1'b0;
            rank_next  = '0;
        end
        else if (op.touch)
        begin
            if (match)
            begin
                rank_next = '0;
                if (op.write_value)
                begin
                    value_next = op.value;
                end
            end
            else if (valid_reg && (rank_reg < op_rank))
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
        else if (op.insert)
        begin
            priority if (is_slot)
            begin
                valid_next = 1'b1;
                rank_next  = '0;
                key_next   = scan.key;
                value_next = op.value;
            end
            else if (is_victim)
            begin
                valid_next = 1'b0;
                rank_next  = '0;
            end
            else if (valid_reg)
            begin
                rank_next = rank_reg + 1'b1;
            end
            else
            begin
                rank_next = rank_reg;
            end
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        value_reg    <= value_next;
        tok_reg      <= tok_next;
        tok_rank_reg <= tok_rank_next;
        tok_slot_reg <= tok_slot_next;
    end

    assign tok_out      = tok_reg;
    assign tok_rank_out = tok_rank_reg;
    assign tok_slot_out = tok_slot_reg;
    assign entry_valid  = valid_reg;
    assign entry_match  = match;

endmodule

// File: rtl/core/lru_key_value_cache.sv
// channel | dir | beat contents
// --------+-----+------------------------------
// req     | in  | command, key, value
// rsp     | out | hit, found_value (lookups only)
// cfg     | in  | cfg_we, cfg_wdata = capacity
//
// one item at a time: the search result ripples through the row of cells in the scan state,
// the update is applied in the apply state, and the next request is accepted only in idle
// reset clears all valid bits at once, no sweep; a capacity write clears them too
// a lookup waits in the apply cycle while the previous result is still held on rsp
// req is taken while a finished result waits on rsp
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    lkv_req_if.sink                   req,
    lkv_rsp_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata
);
    import lkv_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int UW = $clog2(ENTRIES + 1);
    localparam int CW = (UW > CAP_W) ? UW : CAP_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IW-1:0]    cnt_reg, cnt_next;
    logic             cmd_reg;
    key_t             key_reg;
    value_t           val_reg;
    logic [CAP_W-1:0] capacity_reg;
    logic [UW-1:0]    used_reg, used_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             rsp_hit_reg;
    value_t           rsp_value_reg;

    logic [CW-1:0]    cap_ext;
    logic [UW-1:0]    cap_eff;
    logic             cap_on;
    logic             accept;
    logic             rsp_free;
    logic             fire;

    scan_t            scan;
    logic [IW-1:0]    victim_rank;
    op_t              op;

    tok_t             tok_w      [ENTRIES+1];
    logic [IW-1:0]    tok_rank_w [ENTRIES+1];
    logic [IW-1:0]    tok_slot_w [ENTRIES+1];
    logic [ENTRIES-1:0] valid_vec;
    logic [ENTRIES-1:0] match_vec;

    assign cap_ext = CW'(capacity_reg);
    assign cap_eff = (cap_ext > CW'(ENTRIES)) ? UW'(ENTRIES) : UW'(cap_ext);
    assign cap_on  = (cap_eff != '0);

    assign accept   = req.valid && req.ready;
    assign rsp_free = !rsp_valid_reg || rsp.ready;
    assign fire     = (state_reg == ST_APPLY) && ((cmd_reg == CMD_UPDATE) || rsp_free);

    assign scan.key    = key_reg;
    assign scan.evict  = cap_on && (used_reg >= cap_eff);
    // the least recent entry holds the highest rank
    assign victim_rank = IW'(used_reg - 1'b1);

    assign tok_w[0]      = '0;
    assign tok_rank_w[0] = '0;
    assign tok_slot_w[0] = '0;

    assign op.touch       = fire && tok_w[ENTRIES].hit && ((cmd_reg == CMD_LOOKUP) || cap_on);
    assign op.write_value = fire && tok_w[ENTRIES].hit && (cmd_reg == CMD_UPDATE) && cap_on;
    assign op.insert      = fire && !tok_w[ENTRIES].hit && (cmd_reg == CMD_UPDATE) && cap_on
                            && tok_w[ENTRIES].slot_found;
    assign op.value       = val_reg;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            lkv_cell #(
                .ENTRIES (ENTRIES),
                .IDX     (gi)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .clear        (cfg_we),
                .scan         (scan),
                .victim_rank  (victim_rank),
                .tok_in       (tok_w[gi]),
                .tok_rank_in  (tok_rank_w[gi]),
                .tok_slot_in  (tok_slot_w[gi]),
                .tok_out      (tok_w[gi+1]),
                .tok_rank_out (tok_rank_w[gi+1]),
                .tok_slot_out (tok_slot_w[gi+1]),
                .op           (op),
                .op_rank      (tok_rank_w[ENTRIES]),
                .op_slot      (tok_slot_w[ENTRIES]),
                .entry_valid  (valid_vec[gi]),
                .entry_match  (match_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IW'(ENTRIES - 1))
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        used_next = used_reg;
        priority if (cfg_we)
        begin
            used_next = '0;
        end
        else if (op.insert && !scan.evict)
        begin
            used_next = used_reg + 1'b1;
        end
        else
        begin
            used_next = used_reg;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        priority if (fire && (cmd_reg == CMD_LOOKUP))
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            capacity_reg  <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.command;
            key_reg <= req.key;
            val_reg <= req.value;
        end
        if (fire && (cmd_reg == CMD_LOOKUP))
        begin
            rsp_hit_reg   <= tok_w[ENTRIES].hit;
            rsp_value_reg <= tok_w[ENTRIES].value;
        end
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.hit         = rsp_hit_reg;
    assign rsp.found_value = rsp_value_reg;

    `LKV_ASSERT_NOW(a_used_matches_valid, 1'b1, $countones(valid_vec) == int'(used_reg), "used count differs from number of valid entries")
    `LKV_ASSERT_NOW(a_used_within_cap, 1'b1, used_reg <= cap_eff, "more entries in use than capacity allows")
    `LKV_ASSERT_NOW(a_single_match, state_reg == ST_APPLY, $onehot0(match_vec), "key stored in more than one entry")
    `LKV_ASSERT_NOW(a_miss_zero, rsp.valid && !rsp.hit, rsp.found_value == '0, "miss returned nonzero value")
    `LKV_ASSERT_NOW(a_result_from_apply, $rose(rsp.valid), $past(state_reg) == ST_APPLY, "result appeared outside apply")

endmodule

// File: tb/sv/lru_key_value_cache_tb.sv
module lru_key_value_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lkv_pkg::*;

    localparam int NSLOTS = 16;
    // long enough for two items to pass through the block
    localparam int DRAIN  = 2 * (NSLOTS + 2) + 4;
    localparam int NPHASE = 12;
    localparam int PHASE_ITEMS = 155;

    typedef enum logic [1:0] {ROW_LOOKUP, ROW_UPDATE, ROW_CAPACITY} row_kind_t;

    typedef struct {
        row_kind_t kind;
        key_t      key;
        value_t    value;
        bit        typed;
        bit        want_hit;
        value_t    want_value;
    } row_t;

    typedef struct {
        logic   hit;
        value_t found_value;
    } lookup_rsp_t;

    localparam key_t KA = 64'h0123_4567_89ab_cdef;
    localparam key_t KB = 64'hfedc_ba98_7654_3210;
    localparam key_t KC = 64'h8000_0000_0000_0001;
    localparam key_t KMAX = 64'hffff_ffff_ffff_ffff;

    row_t directed_rows[25] = '{
        '{ROW_LOOKUP,   64'h0, 32'h0,          1'b1, 1'b0, 32'h0},
        '{ROW_UPDATE,   64'h0, 32'hffff_ffff,  1'b0, 1'b0, 32'h0},
        '{ROW_LOOKUP,   64'h0, 32'h0,          1'b1, 1'b0, 32'h0},
        '{ROW_CAPACITY, 64'h0, 32'd1,          1'b0, 1'b0, 32'h0},
        '{ROW_UPDATE,   KMAX,  32'hffff_ffff,  1'b0, 1'b0, 32'h0},
        '{ROW_LOOKUP,   KMAX,  32'h0,          1'b1, 1'b1, 32'hffff_ffff},
        '{ROW_UPDATE,   64'h0, 32'h0,          1'b0, 1'b0, 32'h0},
        '{ROW_LOOKUP,   KMAX,  32'hffff_ffff,  1'b1, 1'b0, 32'h0},
        '{ROW_LOOKUP,   64'h0, 32'h0,          1'b1, 1'b1, 32'h0},
        '{ROW_CAPACITY, 64'h0, 32'd31,         1'b0, 1'b0, 32'h0},
        '{ROW_LOOKUP,   64'h0, 32'h0,          1'b1, 1'b0, 32'h0},
        '{ROW_UPDATE,   KA,    32'ha5a5_a5a5,  1'b0, 1'b0, 32'h0},
        '{ROW_UPDATE,   KB,    32'h5a5a_5a5a,  1'b0, 1'b0, 32'h0},
        '{ROW_UPDATE,   KA,    32'h0000_0001,  1'b0, 1'b0, 32'h0},
        '{ROW_LOOKUP,   KA,    32'h0,          1'b0, 1'b0, 32'h0},
        '{ROW_LOOKUP,   KB,    32'h0,          1'b0, 1'b0, 32'h0},
        '{ROW_CAPACITY, 64'h0, 32'd2,          1'b0, 1'b0, 32'h0},
        '{ROW_UPDATE,   KA,    32'h1111_1111,  1'b0, 1'b0, 32'h0},
        '{ROW_UPDATE,   KB,    32'h2222_2222,  1'b0, 1'b0, 32'h0},
        '{ROW_LOOKUP,   KA,    32'h0,          1'b0, 1'b0, 32'h0},
        '{ROW_UPDATE,   KC,    32'h3333_3333,  1'b0, 1'b0, 32'h0},
        '{ROW_LOOKUP,   KB,    32'h0,          1'b0, 1'b0, 32'h0},
        '{ROW_LOOKUP,   KC,    32'h0,          1'b0, 1'b0, 32'h0},
        '{ROW_LOOKUP,   KA,    32'h0,          1'b0, 1'b0, 32'h0},
        '{ROW_LOOKUP,   KMAX,  32'h0,          1'b0, 1'b0, 32'h0}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    lkv_req_if req_if ();
    lkv_rsp_if rsp_if ();

    lru_key_value_cache #(.ENTRIES(NSLOTS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // shadow of the cache contents
    bit     slot_valid [NSLOTS];
    key_t   slot_key   [NSLOTS];
    value_t slot_value [NSLOTS];
    int     slot_rank  [NSLOTS];
    int     used_slots;
    int     capacity_reg;

    lookup_rsp_t pending_lookups[$];

    // expectation typed in the table for the beat being offered
    bit     cur_typed;
    bit     cur_want_hit;
    value_t cur_want_value;

    bit quiet;
    int errors;
    int n_lookups, n_updates, n_hits, n_capacity;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8ms;
        $display("%0t: timeout with %0d lookups outstanding", $time, pending_lookups.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // make slot s the most recent; the ones more recent than it age by one
    function automatic void promote(int s);
        for (int i = 0; i < NSLOTS; i++)
            if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s])
                slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    function automatic void cache_apply(input logic cmd, input key_t k, input value_t v,
                                        output bit produces, output bit hit,
                                        output value_t found);
        int slot;
        int lim;
        int victim;
        int free_slot;
        slot = -1;
        victim = -1;
        free_slot = -1;
        hit = 1'b0;
        found = '0;
        for (int i = 0; i < NSLOTS; i++)
            if (slot < 0 && slot_valid[i] && slot_key[i] == k)
                slot = i;
        if (cmd == CMD_LOOKUP)
        begin
            produces = 1'b1;
            if (slot >= 0)
            begin
                promote(slot);
                hit = 1'b1;
                found = slot_value[slot];
            end
            return;
        end
        produces = 1'b0;
        lim = capacity_reg > NSLOTS ? NSLOTS : capacity_reg;
        if (lim == 0)
            return;
        if (slot >= 0)
        begin
            promote(slot);
            slot_value[slot] = v;
            return;
        end
        if (used_slots >= lim)
        begin
            for (int i = 0; i < NSLOTS; i++)
                if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
                    victim = i;
            if (victim >= 0)
            begin
                slot_valid[victim] = 1'b0;
                slot_rank[victim] = 0;
                if (used_slots > 0)
                    used_slots--;
            end
        end
        for (int i = 0; i < NSLOTS; i++)
            if (free_slot < 0 && !slot_valid[i])
                free_slot = i;
        if (free_slot < 0)
            return;
        for (int i = 0; i < NSLOTS; i++)
            if (slot_valid[i])
                slot_rank[i]++;
        slot_valid[free_slot] = 1'b1;
        slot_key[free_slot] = k;
        slot_value[free_slot] = v;
        slot_rank[free_slot] = 0;
        used_slots++;
    endfunction

    // called at a falling edge; leaves at the falling edge after acceptance
    task automatic send_req(input logic cmd, input key_t k, input value_t v,
                            input bit typed, input bit want_hit, input value_t want_value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.command <= cmd;
        req_if.key     <= k;
        req_if.value   <= v;
        cur_typed      = typed;
        cur_want_hit   = want_hit;
        cur_want_value = want_value;
        do
            @(posedge clk);
        while (!req_if.ready);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(negedge clk);
        // updates give no beat, the last one may still be in flight
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        capacity_reg = cap;
        for (int i = 0; i < NSLOTS; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_rank[i] = 0;
        end
        used_slots = 0;
        n_capacity++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // sink side stalls
    initial
    begin
        int stall;
        stall = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        bit produces;
        bit hit_p;
        value_t found_p;
        lookup_rsp_t want;
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
            begin
                cache_apply(req_if.command, req_if.key, req_if.value, produces, hit_p, found_p);
                if (req_if.command == CMD_LOOKUP)
                    n_lookups++;
                else
                    n_updates++;
                if (produces)
                begin
                    if (cur_typed)
                    begin
                        hit_p = cur_want_hit;
                        found_p = cur_want_value;
                    end
                    pending_lookups.push_back('{hit_p, found_p});
                end
            end
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (pending_lookups.size() == 0)
                begin
                    $display("%0t: response beat with nothing outstanding, hit %0b value %h",
                             $time, rsp_if.hit, rsp_if.found_value);
                    errors++;
                end
                else
                begin
                    want = pending_lookups.pop_front();
                    if (rsp_if.hit)
                        n_hits++;
                    if (rsp_if.hit !== want.hit)
                    begin
                        $display("%0t: hit mismatch, expected %0b got %0b",
                                 $time, want.hit, rsp_if.hit);
                        errors++;
                    end
                    if (rsp_if.found_value !== want.found_value)
                    begin
                        $display("%0t: found_value mismatch, expected %h got %h",
                                 $time, want.found_value, rsp_if.found_value);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        int caps[NPHASE];
        int cap;
        int psize;
        int r;
        key_t pool[$];
        key_t k;
        errors = 0;
        n_lookups = 0;
        n_updates = 0;
        n_hits = 0;
        n_capacity = 0;
        quiet = 1'b0;
        used_slots = 0;
        capacity_reg = 0;
        cur_typed = 1'b0;
        cur_want_hit = 1'b0;
        cur_want_value = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.command = CMD_LOOKUP;
        req_if.key = '0;
        req_if.value = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_CAPACITY: set_capacity(directed_rows[i].value[CAP_W-1:0]);
                ROW_LOOKUP:   send_req(CMD_LOOKUP, directed_rows[i].key, directed_rows[i].value,
                                       directed_rows[i].typed, directed_rows[i].want_hit,
                                       directed_rows[i].want_value);
                default:      send_req(CMD_UPDATE, directed_rows[i].key, directed_rows[i].value,
                                       1'b0, 1'b0, '0);
            endcase
        end

        caps = '{16, 1, 0, 31, 2, 20, 3, 16, 0, 0, 15, 16};
        caps[8] = $urandom_range(2, 15);
        caps[9] = $urandom_range(4, 12);
        for (int p = 0; p < NPHASE; p++)
        begin
            cap = caps[p];
            set_capacity(cap[CAP_W-1:0]);
            quiet = (p % 4 == 3);
            // a pool slightly larger than the capacity gives both hits and evictions
            pool.delete();
            psize = (cap > NSLOTS ? NSLOTS : cap) + $urandom_range(1, 6);
            for (int j = 0; j < psize; j++)
                pool.push_back({$urandom, $urandom});
            repeat (PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                k = pool[$urandom_range(0, psize - 1)];
                if (r >= 93)
                    k = {$urandom, $urandom};
                else if (r >= 85)
                    k = k ^ (64'd1 << $urandom_range(0, 63));
                send_req($urandom_range(0, 1) ? CMD_UPDATE : CMD_LOOKUP, k, $urandom,
                         1'b0, 1'b0, '0);
            end
        end
        quiet = 1'b0;

        wait_idle();
        $display("covered %0d lookups (%0d hits) and %0d updates", n_lookups, n_hits, n_updates);
        $display("over %0d capacity settings from 0 to 31", n_capacity);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
